FILE: hdl/kcp_pkg.sv
// package for the keyed color packetizer: result and queue entry types,
// report sizing constants, the no-led position table and its derived lookups
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kcp_pkg;

  localparam int HEADER_BYTES = 9;
  localparam int REPORT_BYTES = 65;
  localparam int GROUP_BYTES  = 4;
  localparam int SKIP_COUNT   = 22;

  localparam int SKIP_TBL_DEPTH = 32;
  localparam int SKIP_PTR_W     = 5;
  localparam int SKIP_RUN_W     = 6;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int SLOT_W   = 4;
  localparam int SLOTS    = 16;
  localparam int REPORT_W = 6;
  localparam int BRIGHT_W = 3;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 3'd4;

  // register map, by word index
  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_KEY_OFFSET = 1'b1;

  typedef logic [7:0]            skip_pos_tbl_t [SKIP_TBL_DEPTH];
  typedef logic [SKIP_RUN_W-1:0] skip_run_tbl_t [SKIP_TBL_DEPTH];
  typedef logic [SKIP_PTR_W-1:0] skip_ptr_tbl_t [SKIP_TBL_DEPTH];

  // physical positions that carry no led
  localparam skip_pos_tbl_t SKIP_TABLE = '{
    8'd1,   8'd17,  8'd18,  8'd19,  8'd20,  8'd75,  8'd77,  8'd78,
    8'd79,  8'd83,  8'd85,  8'd96,  8'd98,  8'd100, 8'd108, 8'd109,
    8'd111, 8'd112, 8'd113, 8'd116, 8'd123, 8'd125, 8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
  };

  function automatic int next_ptr(int p);
    int n;
    n = p + 1;
    if (n >= SKIP_COUNT || n >= SKIP_TBL_DEPTH) begin
      n = 0;
    end
    return n;
  endfunction

  // length of the run of skipped positions starting at a table entry
  function automatic skip_run_tbl_t build_run();
    skip_run_tbl_t t;
    int ptr;
    int pos;
    int cnt;
    bit done;
    for (int p = 0; p < SKIP_TBL_DEPTH; p++) begin
      ptr  = p;
      pos  = int'(SKIP_TABLE[p]);
      cnt  = 0;
      done = 1'b0;
      for (int i = 0; i < SKIP_COUNT; i++) begin
        if (!done) begin
          if (int'(SKIP_TABLE[ptr]) != pos) begin
            done = 1'b1;
          end else begin
            ptr = next_ptr(ptr);
            pos = (pos + 1) % 256;
            cnt = cnt + 1;
          end
        end
      end
      t[p] = SKIP_RUN_W'(cnt);
    end
    return t;
  endfunction

  // table pointer after the run starting at a table entry
  function automatic skip_ptr_tbl_t build_next();
    skip_ptr_tbl_t t;
    int ptr;
    int pos;
    bit done;
    for (int p = 0; p < SKIP_TBL_DEPTH; p++) begin
      ptr  = p;
      pos  = int'(SKIP_TABLE[p]);
      done = 1'b0;
      for (int i = 0; i < SKIP_COUNT; i++) begin
        if (!done) begin
          if (int'(SKIP_TABLE[ptr]) != pos) begin
            done = 1'b1;
          end else begin
            ptr = next_ptr(ptr);
            pos = (pos + 1) % 256;
          end
        end
      end
      t[p] = SKIP_PTR_W'(ptr);
    end
    return t;
  endfunction

  localparam skip_run_tbl_t SKIP_RUN  = build_run();
  localparam skip_ptr_tbl_t SKIP_NEXT = build_next();

  // per slot: the report closes after this group
  function automatic logic [SLOTS-1:0] build_close();
    logic [SLOTS-1:0] m;
    int used;
    for (int s = 0; s < SLOTS; s++) begin
      used = HEADER_BYTES + GROUP_BYTES * (s + 1);
      m[s] = (used + HEADER_BYTES >= REPORT_BYTES) || (s == SLOTS - 1);
    end
    return m;
  endfunction

  // per slot: a terminator byte still fits after this group
  function automatic logic [SLOTS-1:0] build_fits();
    logic [SLOTS-1:0] m;
    int used;
    for (int s = 0; s < SLOTS; s++) begin
      used = HEADER_BYTES + GROUP_BYTES * (s + 1);
      m[s] = (used + GROUP_BYTES < REPORT_BYTES);
    end
    return m;
  endfunction

  localparam logic [SLOTS-1:0] SLOT_CLOSE = build_close();
  localparam logic [SLOTS-1:0] SLOT_FITS  = build_fits();

  // one classified color, as queued between front and back
  typedef struct packed {
    logic [7:0]          key_id;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [SLOT_W-1:0]   slot;
    logic [REPORT_W-1:0] report_index;
    logic                report_close;
    logic                terminator_after;
    logic                needs_term_report;
  } kcp_grp_t;

  // one result beat
  typedef struct packed {
    logic [7:0]          key_id;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [SLOT_W-1:0]   slot;
    logic [REPORT_W-1:0] report_index;
    logic                report_close;
    logic                terminator_after;
    logic                terminator_only;
    logic [BRIGHT_W-1:0] header_brightness;
    logic                run_last;
  } kcp_res_t;

endpackage

`default_nettype wire

FILE: hdl/keyed_color_packetizer_unit.sv
// Keyed color packetizer: takes one RGB color per beat and emits one result
// beat per color (key id, color, slot, report number, close and terminator
// flags). A color is accepted every cycle while the four-entry queue between
// the front end and the output stage has room; the no-led skip table is
// resolved by a single lookup per color, so skips never stall the input.
// Each color leaves as one output beat, through the queue and then the
// output register; a frame-end color whose terminator byte does not fit
// adds a second, terminator-only beat. Registers sit on an APB port:
// brightness at 0x0, key offset at 0x4; write them only while the block
// is idle.
// depends on kcp_pkg, kcp_front, kcp_fifo, kcp_back
`timescale 1ns / 1ps
`default_nettype none

module keyed_color_packetizer_unit
  import kcp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // apb configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  // color input
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          red_i,
  input  wire logic [7:0]          green_i,
  input  wire logic [7:0]          blue_i,
  input  wire logic                frame_end_i,
  // result output
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [7:0]               key_id_o,
  output logic [7:0]               out_red_o,
  output logic [7:0]               out_green_o,
  output logic [7:0]               out_blue_o,
  output logic [SLOT_W-1:0]        slot_o,
  output logic [REPORT_W-1:0]      report_index_o,
  output logic                     report_close_o,
  output logic                     terminator_after_o,
  output logic                     terminator_only_o,
  output logic [BRIGHT_W-1:0]      header_brightness_o,
  output logic                     run_last_o
);

  logic [BRIGHT_W-1:0] brightness_q;
  logic [7:0]          key_offset_q;
  logic                cfg_wr;
  logic                reg_sel;

  logic                in_accept;
  logic                fifo_full;
  logic                fifo_empty;
  logic                fifo_pop;
  kcp_grp_t            grp_in;
  kcp_grp_t            grp_out;
  kcp_res_t            res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= BRIGHT_RESET;
      key_offset_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_BRIGHTNESS: brightness_q <= pwdata[BRIGHT_W-1:0];
        REG_KEY_OFFSET: key_offset_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BRIGHTNESS: prdata = {{(32-BRIGHT_W){1'b0}}, brightness_q};
      REG_KEY_OFFSET: prdata = {24'd0, key_offset_q};
      default:        prdata = '0;
    endcase
  end

  assign in_stall_o = fifo_full;
  assign in_accept  = in_valid_i && !fifo_full;

  kcp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .frame_end_i  (frame_end_i),
    .key_offset_i (key_offset_q),
    .grp_o        (grp_in)
  );

  kcp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (grp_in),
    .full_o      (fifo_full),
    .pop_i       (fifo_pop),
    .pop_data_o  (grp_out),
    .empty_o     (fifo_empty)
  );

  kcp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grp_i        (grp_out),
    .empty_i      (fifo_empty),
    .pop_o        (fifo_pop),
    .brightness_i (brightness_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res)
  );

  assign key_id_o            = res.key_id;
  assign out_red_o           = res.red;
  assign out_green_o         = res.green;
  assign out_blue_o          = res.blue;
  assign slot_o              = res.slot;
  assign report_index_o      = res.report_index;
  assign report_close_o      = res.report_close;
  assign terminator_after_o  = res.terminator_after;
  assign terminator_only_o   = res.terminator_only;
  assign header_brightness_o = res.header_brightness;
  assign run_last_o          = res.run_last;

endmodule

`default_nettype wire

FILE: hdl/kcp_front.sv
// front end: steps past no-led positions, forms key ids and decides slot,
// report closing and terminator placement per accepted color
// depends on kcp_pkg
`timescale 1ns / 1ps
`default_nettype none

module kcp_front
  import kcp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  input  wire logic       frame_end_i,
  input  wire logic [7:0] key_offset_i,
  output kcp_grp_t        grp_o
);

  logic [7:0]            pos_q, pos_d;
  logic [SKIP_PTR_W-1:0] ptr_q, ptr_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [REPORT_W-1:0]   rep_q, rep_d;

  logic                  skip_hit;
  logic [7:0]            pos_s;
  logic [SKIP_PTR_W-1:0] ptr_s;
  logic                  close;
  logic                  fits;

  // a whole run of consecutive no-led positions resolves in one lookup
  assign skip_hit = (SKIP_TABLE[ptr_q] == pos_q);
  assign pos_s    = skip_hit ? pos_q + 8'(SKIP_RUN[ptr_q]) : pos_q;
  assign ptr_s    = skip_hit ? SKIP_NEXT[ptr_q] : ptr_q;

  assign close = frame_end_i | SLOT_CLOSE[slot_q];
  assign fits  = SLOT_FITS[slot_q];

  always_comb begin
    grp_o.key_id            = pos_s + key_offset_i;
    grp_o.red               = red_i;
    grp_o.green             = green_i;
    grp_o.blue              = blue_i;
    grp_o.slot              = slot_q;
    grp_o.report_index      = rep_q;
    grp_o.report_close      = close;
    grp_o.terminator_after  = frame_end_i & fits;
    grp_o.needs_term_report = frame_end_i & ~fits;
  end

  always_comb begin
    pos_d  = pos_q;
    ptr_d  = ptr_q;
    slot_d = slot_q;
    rep_d  = rep_q;
    if (accept_i) begin
      if (frame_end_i) begin
        pos_d  = '0;
        ptr_d  = '0;
        slot_d = '0;
        rep_d  = '0;
      end else begin
        pos_d = pos_s + 8'd1;
        ptr_d = ptr_s;
        if (close) begin
          slot_d = '0;
          rep_d  = rep_q + REPORT_W'(1);
        end else begin
          slot_d = slot_q + SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      ptr_q  <= '0;
      slot_q <= '0;
      rep_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      ptr_q  <= ptr_d;
      slot_q <= slot_d;
      rep_q  <= rep_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/kcp_fifo.sv
// short queue of classified groups between front and back
// depends on kcp_pkg
`timescale 1ns / 1ps
`default_nettype none

module kcp_fifo
  import kcp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire kcp_grp_t push_data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output kcp_grp_t      pop_data_o,
  output logic          empty_o
);

  kcp_grp_t              mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d;
  logic [FIFO_PTR_W-1:0] rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + FIFO_PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + FIFO_PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + FIFO_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/kcp_back.sv
// back end: drains queued groups into the output register and inserts the
// terminator-only report beat when the last group left no room
// depends on kcp_pkg
`timescale 1ns / 1ps
`default_nettype none

module kcp_back
  import kcp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire kcp_grp_t            grp_i,
  input  wire logic                empty_i,
  output logic                     pop_o,
  input  wire logic [BRIGHT_W-1:0] brightness_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output kcp_res_t                 res_o
);

  logic                valid_q, valid_d;
  logic                pend_q, pend_d;
  logic [REPORT_W-1:0] pend_rep_q;
  kcp_res_t            res_q, res_d;
  logic                load;

  // output register refills when empty or when its beat is taken
  assign load  = !valid_q || !out_stall_i;
  assign pop_o = load && !pend_q && !empty_i;

  always_comb begin
    valid_d = valid_q;
    pend_d  = pend_q;
    res_d   = res_q;
    if (load) begin
      valid_d = pend_q || !empty_i;
      res_d.header_brightness = brightness_i;
      if (pend_q) begin
        res_d.key_id           = '0;
        res_d.red              = '0;
        res_d.green            = '0;
        res_d.blue             = '0;
        res_d.slot             = '0;
        res_d.report_index     = pend_rep_q + REPORT_W'(1);
        res_d.report_close     = 1'b1;
        res_d.terminator_after = 1'b0;
        res_d.terminator_only  = 1'b1;
        res_d.run_last         = 1'b1;
        pend_d                 = 1'b0;
      end else begin
        res_d.key_id           = grp_i.key_id;
        res_d.red              = grp_i.red;
        res_d.green            = grp_i.green;
        res_d.blue             = grp_i.blue;
        res_d.slot             = grp_i.slot;
        res_d.report_index     = grp_i.report_index;
        res_d.report_close     = grp_i.report_close;
        res_d.terminator_after = grp_i.terminator_after;
        res_d.terminator_only  = 1'b0;
        res_d.run_last         = !grp_i.needs_term_report;
        pend_d                 = !empty_i && grp_i.needs_term_report;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (pop_o) begin
      pend_rep_q <= grp_i.report_index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
